### rtl/mhbp_pkg.sv
// Shared types and codes for the header byte parser.
`default_nettype none

package mhbp_pkg;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// Byte tags
	localparam logic [1:0] KIND_IGNORED    = 2'd0;
	localparam logic [1:0] KIND_NAME_FIRST = 2'd1;
	localparam logic [1:0] KIND_NAME_MORE  = 2'd2;
	localparam logic [1:0] KIND_VALUE      = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_RUNNING = 2'd0;
	localparam logic [1:0] STAT_ENDED   = 2'd1;
	localparam logic [1:0] STAT_FAILED  = 2'd2;

	// Error places
	localparam logic [1:0] PLACE_NONE  = 2'd0;
	localparam logic [1:0] PLACE_START = 2'd1;
	localparam logic [1:0] PLACE_NAME  = 2'd2;
	localparam logic [1:0] PLACE_BODY  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_kind;
		logic       commit_field;
		logic [1:0] status;
		logic [1:0] error_place;
	} out_item_t;

endpackage

`default_nettype wire

### rtl/mhbp_tagger.sv
// Parser state machine and result register for the header byte parser.
`default_nettype none

module mhbp_tagger (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire mhbp_pkg::in_item_t   item_s1,
	output mhbp_pkg::out_item_t       result_s2
);

	typedef enum logic [3:0] {
		ST_START     = 4'd0,
		ST_START_CR  = 4'd1,
		ST_NAME      = 4'd2,
		ST_NAME_SP   = 4'd3,
		ST_BODY0     = 4'd4,
		ST_BODY      = 4'd5,
		ST_BODY_CR   = 4'd6,
		ST_BODY_CRLF = 4'd7,
		ST_END_CR    = 4'd8,
		ST_END       = 4'd9,
		ST_FAIL1     = 4'd10,
		ST_FAIL2     = 4'd11,
		ST_FAIL3     = 4'd12
	} state_t;

	state_t              state_q;
	state_t              cur_state;
	state_t              next_state;
	logic [7:0]          c;
	logic                is_print;
	logic                is_blank;
	logic                is_space;
	logic                is_cr;
	logic                is_lf;
	logic                is_colon;
	logic [1:0]          kind;
	logic                commit;
	mhbp_pkg::out_item_t result;

	// Classify the byte
	always_comb begin
		c        = item_s1.data_byte;
		is_print = (c > mhbp_pkg::CH_SP) && (c < mhbp_pkg::CH_DEL);
		is_blank = (c == mhbp_pkg::CH_SP) || (c == mhbp_pkg::CH_TAB);
		is_space = (c == mhbp_pkg::CH_SP) || (c == mhbp_pkg::CH_TAB) ||
			(c == mhbp_pkg::CH_LF) || (c == mhbp_pkg::CH_VT) ||
			(c == mhbp_pkg::CH_FF) || (c == mhbp_pkg::CH_CR);
		is_cr    = (c == mhbp_pkg::CH_CR);
		is_lf    = (c == mhbp_pkg::CH_LF);
		is_colon = (c == mhbp_pkg::CH_COLON);
	end

	// Advance the parser by one byte
	always_comb begin
		cur_state  = item_s1.restart ? ST_START : state_q;
		next_state = cur_state;
		kind       = mhbp_pkg::KIND_IGNORED;
		commit     = 1'b0;
		case (cur_state)
			ST_START_CR: begin
				next_state = is_lf ? ST_END : ST_FAIL1;
			end
			ST_NAME: begin
				if (is_colon) next_state = ST_BODY0;
				else if (is_blank) next_state = ST_NAME_SP;
				else if (is_print) kind = mhbp_pkg::KIND_NAME_MORE;
				else next_state = ST_FAIL2;
			end
			ST_NAME_SP: begin
				if (is_colon) next_state = ST_BODY0;
				else if (!is_blank) next_state = ST_FAIL2;
			end
			ST_BODY0: begin
				if (is_cr) next_state = ST_BODY_CR;
				else if (is_lf) next_state = ST_BODY_CRLF;
				else if (!is_space) begin
					kind       = mhbp_pkg::KIND_VALUE;
					next_state = ST_BODY;
				end
			end
			ST_BODY: begin
				if (is_cr) next_state = ST_BODY_CR;
				else if (is_lf) next_state = ST_BODY_CRLF;
				else kind = mhbp_pkg::KIND_VALUE;
			end
			ST_BODY_CR: begin
				next_state = is_lf ? ST_BODY_CRLF : ST_FAIL3;
			end
			ST_BODY_CRLF: begin
				// folded line keeps the value going, anything else closes the field
				if (is_blank) begin
					kind       = mhbp_pkg::KIND_VALUE;
					next_state = ST_BODY;
				end else begin
					commit = 1'b1;
					if (is_cr) next_state = ST_END_CR;
					else if (is_lf) next_state = ST_END;
					else if (is_print) begin
						kind       = mhbp_pkg::KIND_NAME_FIRST;
						next_state = ST_NAME;
					end else next_state = ST_FAIL3;
				end
			end
			ST_END_CR: begin
				next_state = is_lf ? ST_END : ST_FAIL3;
			end
			ST_END, ST_FAIL1, ST_FAIL2, ST_FAIL3: begin
				next_state = cur_state;
			end
			default: begin
				// header start, and any unreachable code behaves the same
				if (is_blank) next_state = ST_START;
				else if (is_print) begin
					kind       = mhbp_pkg::KIND_NAME_FIRST;
					next_state = ST_NAME;
				end else if (is_cr) next_state = ST_START_CR;
				else if (is_lf) next_state = ST_END;
				else next_state = ST_FAIL1;
			end
		endcase
	end

	// Build the result from the new state
	always_comb begin
		result.out_byte     = c;
		result.byte_kind    = kind;
		result.commit_field = commit;
		result.status       = mhbp_pkg::STAT_RUNNING;
		result.error_place  = mhbp_pkg::PLACE_NONE;
		case (next_state)
			ST_END: begin
				result.status = mhbp_pkg::STAT_ENDED;
			end
			ST_FAIL1: begin
				result.status      = mhbp_pkg::STAT_FAILED;
				result.error_place = mhbp_pkg::PLACE_START;
			end
			ST_FAIL2: begin
				result.status      = mhbp_pkg::STAT_FAILED;
				result.error_place = mhbp_pkg::PLACE_NAME;
			end
			ST_FAIL3: begin
				result.status      = mhbp_pkg::STAT_FAILED;
				result.error_place = mhbp_pkg::PLACE_BODY;
			end
			default: begin
				result.status      = mhbp_pkg::STAT_RUNNING;
				result.error_place = mhbp_pkg::PLACE_NONE;
			end
		endcase
	end

	// Hold state and result; advance on each transfer into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_START;
			result_s2 <= '0;
		end else if (advance) begin
			state_q   <= next_state;
			result_s2 <= result;
		end
	end

endmodule

`default_nettype wire

### rtl/mime_header_byte_parser_core.sv
// Top level of the header byte parser: input register, handshake and tagger.
//
// Usage:
//   Header bytes enter on the in channel (in_valid, in_stall, in_data) and
//   one tagged result per byte leaves on the out channel (out_valid,
//   out_stall, out_data). A transfer happens at a rising edge where valid
//   is high and stall is low.
//   A byte transferred in is held first in the input register and then in
//   the result register, from which it is offered as a result.
//   Throughput: one byte per cycle while out_stall is low; the parser state
//   advances through combinational logic between the input register and
//   the result register.
//   Reset (arst_n low) empties both stages and returns the parser to the
//   header start state. Setting restart on a byte returns the parser to
//   header start before that byte is handled, clearing any ended or failed
//   status.
//   When the receiver stalls, the result register holds its item and the
//   input register keeps one more byte; in_stall rises only once both are
//   full, so no byte is dropped or repeated.
`default_nettype none

module mime_header_byte_parser_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire mhbp_pkg::in_item_t    in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output mhbp_pkg::out_item_t        out_data
);

	logic               in_v_s1;
	mhbp_pkg::in_item_t item_s1;
	logic               out_v_s2;
	logic               s2_open;
	logic               advance;
	logic               in_take;

	// Result stage can load when empty or when its item leaves now
	assign s2_open  = !out_v_s2 || !out_stall;
	assign advance  = in_v_s1 && s2_open;
	assign in_stall = in_v_s1 && !s2_open;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_take) begin
			in_v_s1 <= 1'b1;
		end else if (advance) begin
			in_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s2 <= 1'b0;
		end else if (s2_open) begin
			out_v_s2 <= in_v_s1;
		end
	end

	mhbp_tagger u_tagger (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.result_s2 (out_data)
	);

	assign out_valid = out_v_s2;

endmodule

`default_nettype wire
